>>> hdl/hcbd_pkg.sv
// Package with the types, constants and helpers shared by the chunked body decoder.
package hcbd_pkg;

    localparam int BYTE_W        = 8;
    localparam int SIZE_BITS_DEF = 32;
    localparam int CRLF_W        = 2;

    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

    localparam logic [CRLF_W-1:0] CRLF_SKIP = 2'd2;
    localparam logic [CRLF_W-1:0] CRLF_ONE  = 2'd1;
    localparam logic [CRLF_W-1:0] CRLF_NONE = 2'd0;

    typedef enum logic [2:0] {
        MODE_SIZE    = 3'd0,
        MODE_EXT     = 3'd1,
        MODE_DATA    = 3'd2,
        MODE_CRLF    = 3'd3,
        MODE_TRAILER = 3'd4
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              chunk_last;
        logic              end_of_body;
        logic              size_overflow;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

>>> hdl/hcbd_if.sv
// Channel interfaces for body bytes in and decoded results out.
interface hcbd_in_if;
    logic                         valid;
    logic                         ready;
    logic [hcbd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic                         valid;
    logic                         ready;
    logic [hcbd_pkg::BYTE_W-1:0]  out_byte;
    logic                         chunk_last;
    logic                         end_of_body;
    logic                         size_overflow;

    modport source (output valid, output out_byte, output chunk_last,
                    output end_of_body, output size_overflow, input ready);
    modport sink (input valid, input out_byte, input chunk_last,
                  input end_of_body, input size_overflow, output ready);
endinterface

>>> hdl/hcbd_in_reg.sv
// Input register that holds one body byte until the parser takes it.
module hcbd_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    hcbd_in_if.sink                     body,
    input  logic                        take,
    output logic                        valid,
    output logic [hcbd_pkg::BYTE_W-1:0] data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [hcbd_pkg::BYTE_W-1:0] data_reg;
    logic                        load;

    assign body.ready = !valid_reg || take;
    assign load       = body.valid && body.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= body.in_byte;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> hdl/hcbd_parser.sv
// Chunk framing state machine that turns one body byte into at most one result.
module hcbd_parser #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        consume,
    input  logic [hcbd_pkg::BYTE_W-1:0] in_byte,
    output logic                        res_valid,
    output hcbd_pkg::result_t           res
);

    hcbd_pkg::mode_t                mode_reg;
    hcbd_pkg::mode_t                mode_next;
    logic [SIZE_BITS-1:0]           bytes_left_reg;
    logic [SIZE_BITS-1:0]           bytes_left_next;
    logic                           saw_overflow_reg;
    logic                           saw_overflow_next;
    logic [hcbd_pkg::CRLF_W-1:0]    crlf_left_reg;
    logic [hcbd_pkg::CRLF_W-1:0]    crlf_left_next;
    logic                           trailer_empty_reg;
    logic                           trailer_empty_next;

    hcbd_pkg::hex_t                 hex;
    logic [SIZE_BITS-1:0]           dec;
    logic [SIZE_BITS-1:0]           shifted;
    logic                           too_big;
    logic                           is_lf;
    logic                           is_cr;

    assign hex     = hcbd_pkg::hex_digit(in_byte);
    assign dec     = bytes_left_reg - SIZE_BITS'(1);
    assign shifted = {bytes_left_reg[SIZE_BITS-5:0], hex.val};
    assign too_big = |bytes_left_reg[SIZE_BITS-1 -: 4];
    assign is_lf   = (in_byte == hcbd_pkg::CHAR_LF);
    assign is_cr   = (in_byte == hcbd_pkg::CHAR_CR);

    // Next state.
    always_comb
    begin
        mode_next          = mode_reg;
        bytes_left_next    = bytes_left_reg;
        saw_overflow_next  = saw_overflow_reg;
        crlf_left_next     = crlf_left_reg;
        trailer_empty_next = trailer_empty_reg;
        if (consume)
        begin
            case (mode_reg)
                hcbd_pkg::MODE_EXT:
                begin
                    if (is_lf)
                    begin
                        if (bytes_left_reg == '0)
                        begin
                            mode_next          = hcbd_pkg::MODE_TRAILER;
                            trailer_empty_next = 1'b1;
                        end
                        else
                            mode_next = hcbd_pkg::MODE_DATA;
                    end
                end
                hcbd_pkg::MODE_DATA:
                begin
                    bytes_left_next = dec;
                    if (dec == '0)
                    begin
                        mode_next      = hcbd_pkg::MODE_CRLF;
                        crlf_left_next = hcbd_pkg::CRLF_SKIP;
                    end
                end
                hcbd_pkg::MODE_CRLF:
                begin
                    if (crlf_left_reg == hcbd_pkg::CRLF_SKIP)
                        crlf_left_next = hcbd_pkg::CRLF_ONE;
                    else
                    begin
                        crlf_left_next    = hcbd_pkg::CRLF_NONE;
                        mode_next         = hcbd_pkg::MODE_SIZE;
                        saw_overflow_next = 1'b0;
                        bytes_left_next   = '0;
                    end
                end
                hcbd_pkg::MODE_TRAILER:
                begin
                    if (is_lf)
                    begin
                        if (trailer_empty_reg)
                        begin
                            mode_next         = hcbd_pkg::MODE_SIZE;
                            bytes_left_next   = '0;
                            saw_overflow_next = 1'b0;
                            crlf_left_next    = hcbd_pkg::CRLF_NONE;
                        end
                        trailer_empty_next = 1'b1;
                    end
                    else if (!is_cr)
                        trailer_empty_next = 1'b0;
                end
                default:
                begin
                    mode_next = hcbd_pkg::MODE_SIZE;
                    if (is_lf)
                    begin
                        if (bytes_left_reg == '0)
                        begin
                            mode_next          = hcbd_pkg::MODE_TRAILER;
                            trailer_empty_next = 1'b1;
                        end
                        else
                            mode_next = hcbd_pkg::MODE_DATA;
                    end
                    else if (in_byte == hcbd_pkg::CHAR_SEMI)
                        mode_next = hcbd_pkg::MODE_EXT;
                    else if (hex.ok)
                    begin
                        if (too_big)
                        begin
                            bytes_left_next   = '1;
                            saw_overflow_next = 1'b1;
                        end
                        else
                            bytes_left_next = shifted;
                    end
                end
            endcase
        end
    end

    // Result of the current byte.
    always_comb
    begin
        res_valid         = 1'b0;
        res.out_byte      = '0;
        res.chunk_last    = 1'b0;
        res.end_of_body   = 1'b0;
        res.size_overflow = 1'b0;
        case (mode_reg)
            hcbd_pkg::MODE_DATA:
            begin
                res_valid         = consume;
                res.out_byte      = in_byte;
                res.chunk_last    = (dec == '0);
                res.size_overflow = saw_overflow_reg;
            end
            hcbd_pkg::MODE_TRAILER:
            begin
                res_valid       = consume && is_lf && trailer_empty_reg;
                res.end_of_body = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= hcbd_pkg::MODE_SIZE;
            bytes_left_reg    <= '0;
            saw_overflow_reg  <= 1'b0;
            crlf_left_reg     <= hcbd_pkg::CRLF_NONE;
            trailer_empty_reg <= 1'b1;
        end
        else
        begin
            mode_reg          <= mode_next;
            bytes_left_reg    <= bytes_left_next;
            saw_overflow_reg  <= saw_overflow_next;
            crlf_left_reg     <= crlf_left_next;
            trailer_empty_reg <= trailer_empty_next;
        end
    end

    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && mode_reg == hcbd_pkg::MODE_DATA) |-> res_valid)
        else $error("A data byte was consumed without a result.");

    a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.end_of_body) |=>
        (mode_reg == hcbd_pkg::MODE_SIZE && bytes_left_reg == '0 && !saw_overflow_reg))
        else $error("State was not cleared after end of body.");

    a_crlf_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && mode_reg == hcbd_pkg::MODE_CRLF && crlf_left_reg == hcbd_pkg::CRLF_ONE)
        |=> (mode_reg == hcbd_pkg::MODE_SIZE))
        else $error("The second byte after a chunk did not return to the size line.");

    a_end_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.end_of_body) |->
        (res.out_byte == '0 && !res.chunk_last && !res.size_overflow))
        else $error("An end of body result carries data flags.");

endmodule

>>> hdl/hcbd_out_reg.sv
// Result register that holds one decoded beat until the sink takes it.
module hcbd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hcbd_pkg::result_t res,
    output logic              space,
    hcbd_out_if.source        result
);

    logic              valid_reg;
    logic              valid_next;
    hcbd_pkg::result_t res_reg;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result.valid         = valid_reg;
    assign result.out_byte      = res_reg.out_byte;
    assign result.chunk_last    = res_reg.chunk_last;
    assign result.end_of_body   = res_reg.end_of_body;
    assign result.size_overflow = res_reg.size_overflow;

endmodule

>>> hdl/http_chunked_body_decoder.sv
// Bytes pass the input register, parser and result register. Throughput: one byte
// per cycle while the sink is ready; the input register, the framing state machine
// and the result register each handle one beat per cycle, so bytes flow back to back.
// Only data bytes and the LF that ends the trailer produce a result beat.
// Reset: parser returns to the size line with a zero size; both registers empty.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hcbd_in_if.sink    body,
    hcbd_out_if.source result
);

    logic                        in_valid;
    logic [hcbd_pkg::BYTE_W-1:0] in_data;
    logic                        consume;
    logic                        space;
    logic                        res_valid;
    hcbd_pkg::result_t           res;

    assign consume = in_valid && space;

    hcbd_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .body  (body),
        .take  (consume),
        .valid (in_valid),
        .data  (in_data)
    );

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (consume),
        .in_byte   (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    hcbd_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule
